// ===== hdl/sle_pkg.sv =====
package sle_pkg;

    localparam int FUNC_BITS     = 3;
    localparam int POS_BITS      = 7;
    localparam int ELEM_BITS     = 32;
    localparam int STATUS_BITS   = 3;
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 48;

    localparam logic [FUNC_BITS-1:0] FUNC_INSERT  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_DELETE  = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_LOCATE  = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_REVERSE = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_DUMP    = 3'd4;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR   = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_POS   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [3:0] {
        CMD_HOLD   = 4'b0001,
        CMD_INSERT = 4'b0010,
        CMD_DELETE = 4'b0100,
        CMD_ROTATE = 4'b1000
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_REVERSE = 5'b00100,
        S_DUMP    = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

endpackage

// ===== hdl/sle_cell.sv =====
module sle_cell #(
    parameter int WORD_BITS = 32,
    parameter int IDX_BITS  = 6,
    parameter int CELL_IDX  = 0
) (
    input  logic                        i_clk,
    input  sle_pkg::t_cmd               i_cmd,
    input  logic [IDX_BITS-1:0]         i_arg,
    input  logic signed [WORD_BITS-1:0] i_value,
    input  logic signed [WORD_BITS-1:0] i_head,
    input  logic signed [WORD_BITS-1:0] i_left,
    input  logic signed [WORD_BITS-1:0] i_right,
    output logic signed [WORD_BITS-1:0] o_word
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic signed [WORD_BITS-1:0] r_word;
    logic signed [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd)
            sle_pkg::CMD_INSERT: begin
                if (MY_IDX > i_arg) begin
                    n_word = i_left;
                end else if (MY_IDX == i_arg) begin
                    n_word = i_value;
                end
            end
            sle_pkg::CMD_DELETE: begin
                if (MY_IDX >= i_arg) begin
                    n_word = i_right;
                end
            end
            sle_pkg::CMD_ROTATE: begin
                if (MY_IDX < i_arg) begin
                    n_word = i_right;
                end else if (MY_IDX == i_arg) begin
                    n_word = i_head;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== hdl/sequential_list_engine.sv =====
// Bounded list of signed words held in a row of cells, one word per cell.
// Input channel (i_s_*): one word per operation, func in tuser, position and
// value in tdata. Output channel (o_m_*): result words with status in tuser,
// found position, element and list count in tdata, tlast on the final word.
// Insert and delete shift the cells from the position up at once and clear
// drops the count: the result word is valid in the cycle after the input
// word is accepted, and such operations run at one word per cycle while
// tready stays high. Locate rotates the list through cell 0 and compares
// there, then goes through the done state to the result register. Reverse
// moves the head word to a shrinking end mark, down to cell 1, then goes
// through the done state. Dump sends one word per cycle straight from cell
// 0 while the row rotates and tready is high, count words, the first one
// through the dump state and the result register. Locate of an empty list,
// reverse of at most one word and dump of an empty list answer in the next
// cycle. One operation is in flight at a time, and the next input word is
// taken once the result register is free or being emptied.
// Function codes 6 and 7 are taken and give no result.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared. When the receiver holds tready low,
// the result word holds, the row pauses before each held word, input stalls.
module sequential_list_engine #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // position [6:0], value [38:7], zero [39]
    input  logic [sle_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    // func [2:0]
    input  logic [sle_pkg::FUNC_BITS-1:0]     i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // found_position [6:0], element [38:7], count [45:39], zero [47:46]
    output logic [sle_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    // status [2:0]
    output logic [sle_pkg::STATUS_BITS-1:0]   o_m_tuser,
    output logic                              o_m_tlast
);

    localparam int LW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = ((LW > sle_pkg::POS_BITS) ? LW : sle_pkg::POS_BITS) + 1;

    sle_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_step, n_step;
    logic [IW-1:0]   r_end, n_end;
    logic signed [WORD_BITS-1:0] r_val, n_val;
    logic            r_hit, n_hit;
    logic [LW-1:0]   r_hit_pos, n_hit_pos;
    logic            r_locate, n_locate;

    logic                                r_out_valid, n_out_valid;
    logic [sle_pkg::STATUS_BITS-1:0]     r_out_status;
    logic [sle_pkg::POS_BITS-1:0]        r_out_pos;
    logic signed [sle_pkg::ELEM_BITS-1:0] r_out_elem;
    logic [sle_pkg::POS_BITS-1:0]        r_out_count;
    logic                                r_out_last;

    logic                                w_emit;
    logic [sle_pkg::STATUS_BITS-1:0]     w_emit_status;
    logic [sle_pkg::POS_BITS-1:0]        w_emit_pos;
    logic signed [sle_pkg::ELEM_BITS-1:0] w_emit_elem;
    logic                                w_emit_last;

    logic [sle_pkg::FUNC_BITS-1:0]        w_in_func;
    logic [sle_pkg::POS_BITS-1:0]         w_in_pos;
    logic signed [sle_pkg::ELEM_BITS-1:0] w_in_value;
    logic signed [WORD_BITS-1:0]          w_in_word;
    logic [CW-1:0]   w_pos_c, w_len_c;
    logic [IW-1:0]   w_pos_idx, w_last_idx;
    logic            w_out_free, w_in_fire, w_step_last;

    sle_pkg::t_cmd   w_cmd;
    logic [IW-1:0]   w_arg;
    logic signed [WORD_BITS-1:0] w_word [DEPTH];
    logic signed [WORD_BITS-1:0] w_head;

    assign w_in_func  = i_s_tuser;
    assign w_in_pos   = i_s_tdata[6:0];
    assign w_in_value = i_s_tdata[38:7];
    assign w_in_word  = WORD_BITS'(w_in_value);
    assign w_pos_c    = CW'(w_in_pos);
    assign w_len_c    = CW'(r_len);
    assign w_pos_idx  = IW'(w_pos_c - CW'(1));
    assign w_last_idx = IW'(r_len - LW'(1));
    assign w_head     = w_word[0];
    assign w_step_last = (r_step == r_len - LW'(1));

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == sle_pkg::S_IDLE) && w_out_free;
    assign w_in_fire  = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_step    = r_step;
        n_end     = r_end;
        n_val     = r_val;
        n_hit     = r_hit;
        n_hit_pos = r_hit_pos;
        n_locate  = r_locate;
        w_cmd     = sle_pkg::CMD_HOLD;
        w_arg     = '0;
        w_emit        = 1'b0;
        w_emit_status = sle_pkg::ST_OK;
        w_emit_pos    = '0;
        w_emit_elem   = '0;
        w_emit_last   = 1'b1;
        case (r_state)
            sle_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    case (w_in_func)
                        sle_pkg::FUNC_INSERT: begin
                            w_emit = 1'b1;
                            if (w_in_pos == '0 || w_pos_c > w_len_c + CW'(1)) begin
                                w_emit_status = sle_pkg::ST_BAD_POS;
                            end else if (r_len == LW'(DEPTH)) begin
                                w_emit_status = sle_pkg::ST_FULL;
                            end else begin
                                w_cmd = sle_pkg::CMD_INSERT;
                                w_arg = w_pos_idx;
                                n_len = r_len + LW'(1);
                            end
                        end
                        sle_pkg::FUNC_DELETE: begin
                            w_emit = 1'b1;
                            if (w_in_pos == '0 || w_pos_c > w_len_c) begin
                                w_emit_status = sle_pkg::ST_BAD_POS;
                            end else begin
                                w_cmd = sle_pkg::CMD_DELETE;
                                w_arg = w_pos_idx;
                                n_len = r_len - LW'(1);
                            end
                        end
                        sle_pkg::FUNC_LOCATE: begin
                            if (r_len == '0) begin
                                w_emit        = 1'b1;
                                w_emit_status = sle_pkg::ST_NOT_FOUND;
                            end else begin
                                n_step    = '0;
                                n_hit     = 1'b0;
                                n_hit_pos = '0;
                                n_val     = w_in_word;
                                n_locate  = 1'b1;
                                n_state   = sle_pkg::S_SCAN;
                            end
                        end
                        sle_pkg::FUNC_REVERSE: begin
                            if (r_len <= LW'(1)) begin
                                w_emit = 1'b1;
                            end else begin
                                n_end    = w_last_idx;
                                n_locate = 1'b0;
                                n_state  = sle_pkg::S_REVERSE;
                            end
                        end
                        sle_pkg::FUNC_DUMP: begin
                            if (r_len == '0) begin
                                w_emit        = 1'b1;
                                w_emit_status = sle_pkg::ST_EMPTY;
                            end else begin
                                n_step  = '0;
                                n_state = sle_pkg::S_DUMP;
                            end
                        end
                        sle_pkg::FUNC_CLEAR: begin
                            w_emit = 1'b1;
                            n_len  = '0;
                        end
                        default: begin
                            n_state = sle_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sle_pkg::S_SCAN: begin
                w_cmd  = sle_pkg::CMD_ROTATE;
                w_arg  = w_last_idx;
                n_step = r_step + LW'(1);
                if (w_head == r_val && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_pos = r_step + LW'(1);
                end
                if (w_step_last) begin
                    n_state = sle_pkg::S_DONE;
                end
            end
            sle_pkg::S_REVERSE: begin
                w_cmd = sle_pkg::CMD_ROTATE;
                w_arg = r_end;
                n_end = r_end - IW'(1);
                if (r_end == IW'(1)) begin
                    n_state = sle_pkg::S_DONE;
                end
            end
            sle_pkg::S_DUMP: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_pos  = sle_pkg::POS_BITS'(r_step + LW'(1));
                    w_emit_elem = sle_pkg::ELEM_BITS'(w_head);
                    w_emit_last = w_step_last;
                    w_cmd       = sle_pkg::CMD_ROTATE;
                    w_arg       = w_last_idx;
                    n_step      = r_step + LW'(1);
                    if (w_step_last) begin
                        n_state = sle_pkg::S_IDLE;
                    end
                end
            end
            sle_pkg::S_DONE: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = sle_pkg::S_IDLE;
                    if (r_locate && !r_hit) begin
                        w_emit_status = sle_pkg::ST_NOT_FOUND;
                    end else if (r_locate) begin
                        w_emit_pos = sle_pkg::POS_BITS'(r_hit_pos);
                    end
                end
            end
            default: begin
                n_state = sle_pkg::S_IDLE;
            end
        endcase
        n_out_valid = w_emit || (r_out_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sle_pkg::S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_end     <= n_end;
        r_val     <= n_val;
        r_hit     <= n_hit;
        r_hit_pos <= n_hit_pos;
        r_locate  <= n_locate;
        if (w_emit) begin
            r_out_status <= w_emit_status;
            r_out_pos    <= w_emit_pos;
            r_out_elem   <= w_emit_elem;
            r_out_count  <= sle_pkg::POS_BITS'(n_len);
            r_out_last   <= w_emit_last;
        end
    end

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        sle_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX_BITS  (IW),
            .CELL_IDX  (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_arg   (w_arg),
            .i_value (w_in_word),
            .i_head  (w_head),
            .i_left  (w_word[(j == 0) ? 0 : j - 1]),
            .i_right (w_word[(j == DEPTH - 1) ? j : j + 1]),
            .o_word  (w_word[j])
        );
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {2'b00, r_out_count, r_out_elem, r_out_pos};

endmodule

// ===== hdl/sle_checker.sv =====
module sle_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [sle_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    input logic [sle_pkg::FUNC_BITS-1:0]     i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [sle_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    input logic [sle_pkg::STATUS_BITS-1:0]   o_m_tuser,
    input logic                              o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != sle_pkg::ST_OK |->
            o_m_tlast && o_m_tdata[6:0] == '0 && o_m_tdata[38:7] == '0)
        else $error("error status word carries data or misses last");

    a_dump_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |->
            o_m_tuser == sle_pkg::ST_OK && o_m_tdata[6:0] != '0)
        else $error("non-final word is not a dumped entry");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word present right after reset");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
